// ===== rtl/ps2sle_pkg.sv =====
`default_nettype none
package ps2sle_pkg;

  // line buffer geometry
  localparam int LINE_MAX    = 31;
  localparam int STORE_DEPTH = 31;
  localparam int LEN_W       = 5;
  localparam int CHAR_W      = 7;

  // result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // special characters
  localparam logic [CHAR_W-1:0] CH_BS = 7'h08;
  localparam logic [CHAR_W-1:0] CH_NL = 7'h0A;

  // key operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_CHAR   = 3'd1;
  localparam logic [2:0] OP_BKSP   = 3'd2;
  localparam logic [2:0] OP_ENTER  = 3'd3;
  localparam logic [2:0] OP_RECALL = 3'd4;

  // scan codes
  localparam logic [7:0] SC_TAB       = 8'h0F;
  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
  localparam logic [7:0] SC_CAPS      = 8'h3A;
  localparam logic [7:0] SC_UP        = 8'h48;
  localparam logic [7:0] SC_MAP_LAST  = 8'd57;

  typedef struct packed {
    logic [2:0]        op;
    logic [CHAR_W-1:0] ch;
  } key_cmd_t;

  localparam logic [CHAR_W-1:0] PLAIN_MAP [0:57] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [CHAR_W-1:0] UPPER_MAP [0:57] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

endpackage
`default_nettype wire

// ===== rtl/ps2sle_in_if.sv =====
`default_nettype none
interface ps2sle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scancode;

  modport source (output valid, output scancode, input ready);
  modport sink (input valid, input scancode, output ready);
endinterface
`default_nettype wire

// ===== rtl/ps2sle_out_if.sv =====
`default_nettype none
interface ps2sle_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     out_kind;
  logic [ps2sle_pkg::CHAR_W-1:0]  out_char;
  logic                           last_of_run;

  modport source (output valid, output out_kind, output out_char, output last_of_run,
                  input ready);
  modport sink (input valid, input out_kind, input out_char, input last_of_run,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/ps2sle_ram.sv =====
`default_nettype none
module ps2sle_ram #(
  parameter int DEPTH = 31,
  parameter int WIDTH = 7
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/ps2sle_keymap.sv =====
`default_nettype none
module ps2sle_keymap (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           code,
  input  wire logic                 apply,
  input  wire logic                 hist_any,
  output ps2sle_pkg::key_cmd_t      cmd
);

  logic                          shift_held;
  logic                          caps_on;
  logic [ps2sle_pkg::CHAR_W-1:0] lo;
  logic [ps2sle_pkg::CHAR_W-1:0] hi;
  logic [ps2sle_pkg::CHAR_W-1:0] ch;
  logic                          use_upper;
  logic                          alpha_key;

  // modifier tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
    end else if (apply) begin
      if (code == ps2sle_pkg::SC_LSHIFT || code == ps2sle_pkg::SC_RSHIFT) begin
        shift_held <= 1'b1;
      end else if (code == ps2sle_pkg::SC_LSHIFT_UP || code == ps2sle_pkg::SC_RSHIFT_UP) begin
        shift_held <= 1'b0;
      end else if (code == ps2sle_pkg::SC_CAPS) begin
        caps_on <= ~caps_on;
      end
    end
  end

  always_comb begin
    lo        = '0;
    hi        = '0;
    if (code <= ps2sle_pkg::SC_MAP_LAST) begin
      lo = ps2sle_pkg::PLAIN_MAP[code[5:0]];
      hi = ps2sle_pkg::UPPER_MAP[code[5:0]];
    end
    alpha_key = (lo >= 7'h61) && (lo <= 7'h7A);
    use_upper = shift_held ^ (alpha_key & caps_on);
    ch        = use_upper ? hi : lo;

    cmd.op = ps2sle_pkg::OP_NONE;
    cmd.ch = ch;
    if (code == ps2sle_pkg::SC_TAB) begin
      cmd.op = ps2sle_pkg::OP_NONE;
    end else if (code == ps2sle_pkg::SC_UP && hist_any) begin
      cmd.op = ps2sle_pkg::OP_RECALL;
    end else if (code == ps2sle_pkg::SC_LSHIFT || code == ps2sle_pkg::SC_RSHIFT) begin
      cmd.op = ps2sle_pkg::OP_NONE;
    end else if (code <= ps2sle_pkg::SC_MAP_LAST) begin
      if (ch == ps2sle_pkg::CH_NL) begin
        cmd.op = ps2sle_pkg::OP_ENTER;
      end else if (ch == ps2sle_pkg::CH_BS) begin
        cmd.op = ps2sle_pkg::OP_BKSP;
      end else if (ch != '0) begin
        cmd.op = ps2sle_pkg::OP_CHAR;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ps2sle_sequencer.sv =====
`default_nettype none
module ps2sle_sequencer (
  input  wire logic clk,
  input  wire logic rst,
  ps2sle_in_if.sink     keys,
  ps2sle_out_if.source  text
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_BKSP   = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_ENDMK  = 3'd4;

  localparam int LW = ps2sle_pkg::LEN_W;
  localparam int CW = ps2sle_pkg::CHAR_W;

  logic [2:0]    state, state_next;
  logic [7:0]    code;
  logic [LW-1:0] len, len_next;
  logic [LW-1:0] hist_len, hist_len_next;
  logic [LW-1:0] idx, idx_next;
  logic          to_hist, to_hist_next;

  logic          o_valid;
  logic [1:0]    o_kind;
  logic [CW-1:0] o_char;
  logic          o_last;

  logic          slot_free;
  logic          emit;
  logic [1:0]    e_kind;
  logic [CW-1:0] e_char;
  logic          e_last;

  logic          line_we;
  logic [LW-1:0] line_waddr;
  logic [CW-1:0] line_wdata;
  logic [CW-1:0] line_rdata;
  logic          hist_we;
  logic [CW-1:0] hist_rdata;
  logic [LW-1:0] last_idx;

  ps2sle_pkg::key_cmd_t cmd;

  ps2sle_keymap u_keymap (
    .clk      (clk),
    .rst      (rst),
    .code     (code),
    .apply    (state == S_DECODE),
    .hist_any (hist_len != '0),
    .cmd      (cmd)
  );

  // read address follows the next copy index so data lines up with idx
  ps2sle_ram #(.DEPTH(ps2sle_pkg::STORE_DEPTH), .WIDTH(CW)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (idx_next),
    .rdata (line_rdata)
  );

  ps2sle_ram #(.DEPTH(ps2sle_pkg::STORE_DEPTH), .WIDTH(CW)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (idx),
    .wdata (line_rdata),
    .raddr (idx_next),
    .rdata (hist_rdata)
  );

  assign slot_free        = !o_valid || text.ready;
  assign keys.ready       = (state == S_IDLE);
  assign text.valid       = o_valid;
  assign text.out_kind    = o_kind;
  assign text.out_char    = o_char;
  assign text.last_of_run = o_last;
  assign last_idx         = (to_hist ? len : hist_len) - LW'(1);

  always_comb begin
    state_next    = state;
    len_next      = len;
    hist_len_next = hist_len;
    idx_next      = idx;
    to_hist_next  = to_hist;
    emit          = 1'b0;
    e_kind        = ps2sle_pkg::KIND_ECHO;
    e_char        = '0;
    e_last        = 1'b0;
    line_we       = 1'b0;
    line_waddr    = idx;
    line_wdata    = hist_rdata;
    hist_we       = 1'b0;

    case (state)
      S_IDLE: begin
        if (keys.valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cmd.op)
          ps2sle_pkg::OP_CHAR: begin
            if (len >= LW'(ps2sle_pkg::LINE_MAX)) begin
              state_next = S_IDLE;
            end else if (slot_free) begin
              emit       = 1'b1;
              e_char     = cmd.ch;
              e_last     = 1'b1;
              line_we    = 1'b1;
              line_waddr = len;
              line_wdata = cmd.ch;
              len_next   = len + LW'(1);
              state_next = S_IDLE;
            end
          end
          ps2sle_pkg::OP_BKSP: begin
            if (len == '0) begin
              state_next = S_IDLE;
            end else if (slot_free) begin
              emit       = 1'b1;
              e_char     = ps2sle_pkg::CH_BS;
              e_last     = 1'b1;
              len_next   = len - LW'(1);
              state_next = S_IDLE;
            end
          end
          ps2sle_pkg::OP_ENTER: begin
            if (slot_free) begin
              emit         = 1'b1;
              e_char       = ps2sle_pkg::CH_NL;
              to_hist_next = 1'b1;
              state_next   = (len != '0) ? S_COPY : S_ENDMK;
            end
          end
          ps2sle_pkg::OP_RECALL: begin
            to_hist_next = 1'b0;
            state_next   = (len != '0) ? S_BKSP : S_COPY;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_BKSP: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_char   = ps2sle_pkg::CH_BS;
          len_next = len - LW'(1);
          if (len == LW'(1)) begin
            state_next = S_COPY;
          end
        end
      end
      S_COPY: begin
        if (slot_free) begin
          emit = 1'b1;
          if (to_hist) begin
            e_kind  = ps2sle_pkg::KIND_LINE;
            e_char  = line_rdata;
            hist_we = 1'b1;
          end else begin
            e_char  = hist_rdata;
            e_last  = (idx == last_idx);
            line_we = 1'b1;
          end
          if (idx == last_idx) begin
            idx_next = '0;
            if (to_hist) begin
              hist_len_next = len;
              len_next      = '0;
              state_next    = S_ENDMK;
            end else begin
              len_next   = hist_len;
              state_next = S_IDLE;
            end
          end else begin
            idx_next = idx + LW'(1);
          end
        end
      end
      S_ENDMK: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_kind     = ps2sle_pkg::KIND_END;
          e_last     = 1'b1;
          len_next   = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      hist_len <= '0;
      idx      <= '0;
      to_hist  <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      len      <= len_next;
      hist_len <= hist_len_next;
      idx      <= idx_next;
      to_hist  <= to_hist_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (text.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (keys.valid && keys.ready) begin
      code <= keys.scancode;
    end
    if (emit) begin
      o_kind <= e_kind;
      o_char <= e_char;
      o_last <= e_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ps2_scancode_line_editor_top.sv =====
// scan-code set 1 line editor
//
// keys: one raw scan-code byte per item (make and break codes). text: result
// items, each an echo character, a character of a completed line, or the end
// marker of a completed line; last_of_run flags the final result of a key.
// both channels move an item when valid and ready are high at a clock edge.
//
// a key is taken in the idle state and decoded in the next cycle; a
// single-result key writes its item into the output register from the decode
// state, and the next key is taken once the sequencer is back in idle. enter and
// up-arrow stream one result per cycle, while the output register is free, out
// of the line and history memories (registered read, address run ahead by the
// copy counter): up to 62 results per key. shift, caps lock, tab and unmapped
// codes give no result.
//
// a result waits in the output register while the receiver stalls; the
// sequencer holds its place and resumes as soon as the register frees up.
// keys are taken only between runs.
//
// reset clears shift, caps lock, line and history lengths and the output
// valid; memory contents are left as they are and never read unwritten.
`default_nettype none
module ps2_scancode_line_editor_top (
  input  wire logic     clk,
  input  wire logic     rst,
  ps2sle_in_if.sink     keys,
  ps2sle_out_if.source  text
);

  // all work lives in the sequencer: keymap, line and history memories
  ps2sle_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .keys (keys),
    .text (text)
  );

endmodule
`default_nettype wire
